>>> rtl/nsa_pkg.sv
// ----------------------------------------------------------------------------
// nsa_pkg
// Shared types and constants for the NFA string acceptor: item codes, field
// widths, default sizes and the control bundle of the transition memory.
// ----------------------------------------------------------------------------
package nsa_pkg;

    // Default automaton size.
    localparam int STATES_DEF  = 64;
    localparam int SYMBOLS_DEF = 128;

    // Fixed field widths of the item and result ports.
    localparam int MODE_W      = 3;
    localparam int STATE_FLD_W = 6;
    localparam int SYM_FLD_W   = 7;
    localparam int VEC_W       = 64;

    // Item codes carried on the mode field.
    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_ALL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_ACC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SYM     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    // Enables of the two transition memory ports.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

>>> rtl/nsa_trans_mem.sv
// ----------------------------------------------------------------------------
// nsa_trans_mem
// Transition memory: one row of destination states per (source, symbol)
// pair. One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module nsa_trans_mem
    import nsa_pkg::*;
#(
    parameter int ADDR_W = 13,
    parameter int DATA_W = STATES_DEF
)
(
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/nsa_seq.sv
// ----------------------------------------------------------------------------
// nsa_seq
// Sequencer of the NFA string acceptor: clears the transition memory after
// reset, runs read-modify-write sweeps for transition loads, scans the rows
// of all states for a string symbol, and holds the result register.
// ----------------------------------------------------------------------------
module nsa_seq
    import nsa_pkg::*;
#(
    parameter int STATES  = STATES_DEF,
    parameter int SYMBOLS = SYMBOLS_DEF,
    parameter int ST_W    = $clog2(STATES),
    parameter int SYM_W   = $clog2(SYMBOLS),
    parameter int ADDR_W  = ST_W + SYM_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [STATE_FLD_W-1:0] src_state,
    input  logic [SYM_FLD_W-1:0]   symbol,
    input  logic [STATE_FLD_W-1:0] dst_state,
    input  logic                   accept_value,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   accepted,
    output logic [VEC_W-1:0]       final_states,
    output mem_ctl_t               mem_ctl,
    output logic [ADDR_W-1:0]      mem_wr_addr,
    output logic [STATES-1:0]      mem_wr_data,
    output logic [ADDR_W-1:0]      mem_rd_addr,
    input  logic [STATES-1:0]      mem_rd_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [MODE_W-1:0]   op_reg;
    logic [ST_W-1:0]     src_idx_reg;
    logic [SYM_W-1:0]    sym_idx_reg;
    logic [STATES-1:0]   dst_bit_reg;
    logic                last_reg;
    logic                rd_pend_reg;
    logic [ADDR_W-1:0]   rd_addr_q_reg;
    logic [STATES-1:0]   acc_reg;
    logic [STATES-1:0]   active_reg;
    logic [STATES-1:0]   flags_reg;
    logic                res_acc_reg;
    logic [STATES-1:0]   res_set_reg;
    logic                out_valid_reg;
    logic                accepted_reg;
    logic [STATES-1:0]   final_reg;

    logic [ST_W+STATE_FLD_W-1:0] src_ext;
    logic [ST_W+STATE_FLD_W-1:0] dst_ext;
    logic [SYM_W+SYM_FLD_W-1:0]  sym_ext;
    logic [ST_W-1:0]             src_idx;
    logic [ST_W-1:0]             dst_idx;
    logic [SYM_W-1:0]            sym_idx;
    logic                        src_ok;
    logic                        dst_ok;
    logic                        sym_ok;
    logic [ADDR_W-1:0]           sweep_addr;
    logic                        sweep_last;
    logic                        rd_is_add;
    logic [ST_W-1:0]             rd_state;
    logic [STATES-1:0]           acc_next;

    // Field decode: range checks on the full field, then narrow indexes.
    assign src_ext = {{ST_W{1'b0}}, src_state};
    assign dst_ext = {{ST_W{1'b0}}, dst_state};
    assign sym_ext = {{SYM_W{1'b0}}, symbol};
    assign src_idx = src_ext[ST_W-1:0];
    assign dst_idx = dst_ext[ST_W-1:0];
    assign sym_idx = sym_ext[SYM_W-1:0];
    assign src_ok  = 32'(src_state) < 32'(STATES);
    assign dst_ok  = 32'(dst_state) < 32'(STATES);
    assign sym_ok  = 32'(symbol) < 32'(SYMBOLS);

    always_comb
    begin
        case (op_reg)
            MODE_ADD_ALL:
            begin
                sweep_addr = {src_idx_reg, cnt_reg[SYM_W-1:0]};
                sweep_last = (cnt_reg == ADDR_W'(SYMBOLS - 1));
            end
            MODE_SYM:
            begin
                sweep_addr = {cnt_reg[ST_W-1:0], sym_idx_reg};
                sweep_last = (cnt_reg == ADDR_W'(STATES - 1));
            end
            default:
            begin
                sweep_addr = {src_idx_reg, sym_idx_reg};
                sweep_last = 1'b1;
            end
        endcase
    end

    // The row read in the previous cycle is either written back with the
    // destination added, or folded into the next active set.
    assign rd_is_add = rd_pend_reg && ((op_reg == MODE_ADD) || (op_reg == MODE_ADD_ALL));
    assign rd_state  = rd_addr_q_reg[ADDR_W-1 -: ST_W];
    assign acc_next  = (rd_pend_reg && (op_reg == MODE_SYM) && active_reg[rd_state])
                       ? (acc_reg | mem_rd_data) : acc_reg;

    always_comb
    begin
        mem_ctl.rd_en = (state_reg == ST_SWEEP);
        mem_rd_addr   = sweep_addr;
        if (state_reg == ST_CLEAR)
        begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = cnt_reg;
            mem_wr_data   = '0;
        end
        else
        begin
            mem_ctl.wr_en = rd_is_add;
            mem_wr_addr   = rd_addr_q_reg;
            mem_wr_data   = mem_rd_data | dst_bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            op_reg        <= MODE_ADD;
            src_idx_reg   <= '0;
            sym_idx_reg   <= '0;
            dst_bit_reg   <= '0;
            last_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_addr_q_reg <= '0;
            acc_reg       <= '0;
            active_reg    <= STATES'(1);
            flags_reg     <= '0;
            res_acc_reg   <= 1'b0;
            res_set_reg   <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            final_reg     <= '0;
        end
        else
        begin
            rd_pend_reg   <= (state_reg == ST_SWEEP);
            rd_addr_q_reg <= sweep_addr;
            // A new item starts its accumulation from an empty set.
            acc_reg       <= (in_valid && in_ready) ? '0 : acc_next;
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == {ADDR_W{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= mode;
                        src_idx_reg <= src_idx;
                        sym_idx_reg <= sym_idx;
                        dst_bit_reg <= STATES'(1) << dst_idx;
                        last_reg    <= last;
                        cnt_reg     <= '0;
                        unique case (mode)
                            MODE_ADD:
                            begin
                                if (src_ok && dst_ok && sym_ok)
                                begin
                                    state_reg <= ST_SWEEP;
                                end
                            end
                            MODE_ADD_ALL:
                            begin
                                if (src_ok && dst_ok)
                                begin
                                    state_reg <= ST_SWEEP;
                                end
                            end
                            MODE_SET_ACC:
                            begin
                                if (src_ok)
                                begin
                                    flags_reg[src_idx] <= accept_value;
                                end
                            end
                            MODE_SYM:
                            begin
                                if (sym_ok)
                                begin
                                    state_reg <= ST_SWEEP;
                                end
                                else if (last)
                                begin
                                    res_acc_reg <= 1'b0;
                                    res_set_reg <= '0;
                                    active_reg  <= STATES'(1);
                                    state_reg   <= ST_DONE;
                                end
                                else
                                begin
                                    active_reg <= '0;
                                end
                            end
                            MODE_QUERY:
                            begin
                                res_acc_reg <= flags_reg[0];
                                res_set_reg <= STATES'(1);
                                active_reg  <= STATES'(1);
                                state_reg   <= ST_DONE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (sweep_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if ((op_reg == MODE_SYM) && last_reg)
                    begin
                        res_acc_reg <= |(acc_next & flags_reg);
                        res_set_reg <= acc_next;
                        active_reg  <= STATES'(1);
                        state_reg   <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        if (op_reg == MODE_SYM)
                        begin
                            active_reg <= acc_next;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        accepted_reg  <= res_acc_reg;
                        final_reg     <= res_set_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign final_states = VEC_W'(final_reg);

    // A sweep never reads the row that is being written back in that cycle.
    a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.rd_en && mem_ctl.wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("transition row read and written in the same cycle");

    // Outside the clearing pass a write always follows a read of that row.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && (state_reg != ST_CLEAR)) |-> $past(mem_ctl.rd_en))
        else $error("write-back without a preceding read");

    // Every reported verdict leaves the active set at state 0 alone.
    a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (active_reg == STATES'(1)))
        else $error("active set not restarted after a verdict");

    // An accepting verdict needs at least one active state.
    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> (final_reg != '0))
        else $error("accepted with an empty final set");

    // Items are taken only outside the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> ((state_reg == ST_CLEAR) || (cnt_reg == '0)))
        else $error("clearing pass left early");

endmodule

>>> rtl/nfa_string_acceptor_unit.sv
// ----------------------------------------------------------------------------
// nfa_string_acceptor_unit
// Nondeterministic finite automaton run as a bit-vector set of active states,
// with the transition rows held in one synchronous memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**(clog2(STATES) + clog2(SYMBOLS)) rows
// of the transition memory to zero (8192 at the default size), one row per
// cycle, and takes no item until that pass is done. Every item then occupies
// the block alone, and the time it takes is set by the single read port of
// the transition memory: a transition load is accepted, read and written
// back, a load on all symbols reads and writes back each symbol's row in
// turn, and a string symbol reads the rows of all STATES states for that
// symbol one per cycle and ORs them under the active mask. Writing an
// accepting flag, an out-of-range symbol and unused codes need no memory
// read. The symbol marked last and the empty-string query also pass through
// a result state that places the result in the output register, which holds
// it until the transfer completes; the next item is accepted while a result
// still waits there, and only a second result waits for the first to leave.
// ----------------------------------------------------------------------------
module nfa_string_acceptor_unit
    import nsa_pkg::*;
#(
    parameter int STATES  = STATES_DEF,
    parameter int SYMBOLS = SYMBOLS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [STATE_FLD_W-1:0] src_state,
    input  logic [SYM_FLD_W-1:0]   symbol,
    input  logic [STATE_FLD_W-1:0] dst_state,
    input  logic                   accept_value,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   accepted,
    output logic [VEC_W-1:0]       final_states
);

    // Memory rows are addressed as {source state, symbol}, so no multiply
    // is needed; unused symbol codes simply leave rows that stay zero.
    localparam int ST_W   = $clog2(STATES);
    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int ADDR_W = ST_W + SYM_W;

    mem_ctl_t            mem_ctl;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [STATES-1:0]   mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [STATES-1:0]   mem_rd_data;

    // Sequencer: holds the active set, the accepting flags and the result
    // register, and drives both memory ports.
    nsa_seq #(
        .STATES  (STATES),
        .SYMBOLS (SYMBOLS),
        .ST_W    (ST_W),
        .SYM_W   (SYM_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .src_state    (src_state),
        .symbol       (symbol),
        .dst_state    (dst_state),
        .accept_value (accept_value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .final_states (final_states),
        .mem_ctl      (mem_ctl),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // Transition store, one row of STATES destination bits per entry.
    nsa_trans_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (STATES)
    ) u_trans_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
